[rtl/bdgt_pkg.sv]
// Shared constants for the bounded-degree graph table: operation and status
// codes, default sizes and lane scoring constants. No dependencies.
package bdgt_pkg;

	localparam int MAX_NODES_DEF = 256;
	localparam int SLOTS_DEF     = 4;
	localparam int COORD_W       = 16;

	typedef logic [2:0] op_t;
	typedef logic [2:0] status_t;

	localparam op_t OP_FIND       = 3'd0;
	localparam op_t OP_CONNECT    = 3'd1;
	localparam op_t OP_DISCONNECT = 3'd2;
	localparam op_t OP_DEGREE     = 3'd3;
	localparam op_t OP_NEAREST    = 3'd4;
	localparam op_t OP_CLEAR      = 3'd5;

	localparam status_t ST_OK      = 3'd0;
	localparam status_t ST_FULL    = 3'd1;
	localparam status_t ST_NOSLOT  = 3'd2;
	localparam status_t ST_NOTCONN = 3'd3;
	localparam status_t ST_BADIDX  = 3'd4;

	localparam logic [17:0] LANE_FAR    = 18'h10000;
	localparam logic [17:0] LANE_OFS    = 18'h00100;
	localparam logic [7:0]  LANE_HALF   = 8'h80;
	localparam logic [9:0]  LANE_MARGIN = 10'd2;

endpackage

[rtl/bdgt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on bdgt_pkg for default sizes.
module bdgt_ram #(
	parameter int WIDTH = bdgt_pkg::COORD_W,
	parameter int DEPTH = bdgt_pkg::MAX_NODES_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/bounded_degree_graph_table_top.sv]
// Bounded-degree grid graph table: node coordinates and neighbour slot rows in two RAMs,
// one sequencer and one compare/score unit. Depends on bdgt_pkg and bdgt_ram.
// Clear, unknown op and bad index answer from idle; degree reads node A's slot row;
// connect/disconnect check both rows, then write the updated rows; find-or-add compares
// each stored node, then appends; nearest scores each edge once. One beat at a time.
// Reset empties the table at once (node count one); slot rows are zeroed on append.
module bounded_degree_graph_table_top #(
	parameter int MAX_NODES = bdgt_pkg::MAX_NODES_DEF,
	parameter int SLOTS     = bdgt_pkg::SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [2:0]  op,
	input  logic [7:0]  grid_x,
	input  logic [7:0]  grid_z,
	input  logic [7:0]  node_a,
	input  logic [7:0]  node_b,
	input  logic [15:0] world_x,
	input  logic [15:0] world_z,
	output logic        busy,
	output logic        done,
	output logic [7:0]  node_index,
	output logic [7:0]  other_node,
	output logic        created,
	output logic [2:0]  degree,
	output logic [2:0]  status
);

	localparam int NW = $clog2(MAX_NODES);
	localparam int CW = (NW + 1 > 8) ? NW + 1 : 8;
	localparam int SW = $clog2(SLOTS);
	localparam int JW = $clog2(SLOTS + 1);
	localparam int RW = SLOTS * NW;
	localparam logic [NW:0]   CNT_MAX = (NW + 1)'(MAX_NODES);
	localparam logic [NW:0]   CNT_ONE = (NW + 1)'(1);
	localparam logic [JW-1:0] J_END   = JW'(SLOTS);

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_FA_RD    = 4'd1;
	localparam logic [3:0] S_FA_CMP   = 4'd2;
	localparam logic [3:0] S_FA_NEW   = 4'd3;
	localparam logic [3:0] S_LK_RDA   = 4'd4;
	localparam logic [3:0] S_LK_RDB   = 4'd5;
	localparam logic [3:0] S_LK_EVAL  = 4'd6;
	localparam logic [3:0] S_LK_WRB   = 4'd7;
	localparam logic [3:0] S_NS_ROW   = 4'd8;
	localparam logic [3:0] S_NS_ROWW  = 4'd9;
	localparam logic [3:0] S_NS_SLOT  = 4'd10;
	localparam logic [3:0] S_NS_SCORE = 4'd11;
	localparam logic [3:0] S_NS_CMP   = 4'd12;

	typedef logic [NW-1:0] idx_t;
	typedef logic [SLOTS-1:0][NW-1:0] row_t;

	function automatic logic can_link(row_t r, idx_t v);
		logic ok;
		ok = 1'b0;
		for (int k = 0; k < SLOTS; k++) begin
			if (r[k] == v || r[k] == '0) begin
				ok = 1'b1;
			end
		end
		return ok;
	endfunction

	function automatic logic has_link(row_t r, idx_t v);
		logic ok;
		ok = 1'b0;
		for (int k = 0; k < SLOTS; k++) begin
			if (r[k] == v) begin
				ok = 1'b1;
			end
		end
		return ok;
	endfunction

	function automatic row_t add_link(row_t r, idx_t v);
		row_t o;
		logic stop;
		o = r;
		stop = 1'b0;
		for (int k = 0; k < SLOTS; k++) begin
			if (!stop) begin
				if (r[k] == v) begin
					stop = 1'b1;
				end else if (r[k] == '0) begin
					o[k] = v;
					stop = 1'b1;
				end
			end
		end
		return o;
	endfunction

	function automatic row_t remove_link(row_t r, idx_t v);
		logic [SLOTS:0][NW-1:0] p;
		row_t o;
		logic seen;
		p = {idx_t'(0), r};
		seen = 1'b0;
		for (int k = 0; k < SLOTS; k++) begin
			if (r[k] == v) begin
				seen = 1'b1;
			end
			o[k] = seen ? p[k+1] : r[k];
		end
		return o;
	endfunction

	function automatic logic [2:0] count_used(row_t r);
		logic [JW+2:0] n;
		n = '0;
		for (int k = 0; k < SLOTS; k++) begin
			if (r[k] != '0) begin
				n = n + (JW + 3)'(1);
			end
		end
		return n[2:0];
	endfunction

	function automatic logic [7:0] to_byte(idx_t v);
		logic [NW+7:0] w;
		w = {8'b0, v};
		return w[7:0];
	endfunction

	logic [3:0]    state_q;
	logic [NW:0]   cnt_q;
	logic [2:0]    op_q;
	idx_t          i_q, a_q, b_q, cand_q;
	logic [7:0]    x_q, z_q, ix_q, iz_q;
	logic [15:0]   wx_q, wz_q;
	row_t          rowa_q, row_q, newb_q;
	logic [JW-1:0] j_q;
	logic [16:0]   score_q, best_q;
	logic          best_v_q;
	idx_t          node_q, other_q;
	logic          created_q;
	logic [2:0]    degree_q, status_q;
	logic          done_q;

	logic          coord_we, slot_we;
	idx_t          coord_waddr, coord_raddr, slot_waddr, slot_raddr;
	logic [15:0]   coord_wdata, coord_rdata;
	logic [RW-1:0] slot_wdata, slot_rdata;
	row_t          slot_row, slot_wrow;

	bdgt_ram #(.WIDTH(bdgt_pkg::COORD_W), .DEPTH(MAX_NODES)) u_coord_ram (
		.clk   (clk),
		.we    (coord_we),
		.waddr (coord_waddr),
		.wdata (coord_wdata),
		.raddr (coord_raddr),
		.rdata (coord_rdata)
	);

	bdgt_ram #(.WIDTH(RW), .DEPTH(MAX_NODES)) u_slot_ram (
		.clk   (clk),
		.we    (slot_we),
		.waddr (slot_waddr),
		.wdata (slot_wdata),
		.raddr (slot_raddr),
		.rdata (slot_rdata)
	);

	assign slot_row   = slot_rdata;
	assign slot_wdata = slot_wrow;

	logic [CW-1:0] na_ext, nb_ext, cnt_ext;
	logic          a_ok, b_ok, last_node;
	idx_t          cand;

	assign na_ext    = CW'(node_a);
	assign nb_ext    = CW'(node_b);
	assign cnt_ext   = CW'(cnt_q);
	assign a_ok      = na_ext != '0 && na_ext < cnt_ext;
	assign b_ok      = nb_ext != '0 && nb_ext < cnt_ext;
	assign last_node = ({1'b0, i_q} + CNT_ONE) == cnt_q;
	assign cand      = row_q[j_q[SW-1:0]];

	logic lk_ok, lk_two;
	row_t new_a, new_b;

	always_comb begin
		if (op_q == bdgt_pkg::OP_CONNECT) begin
			lk_ok  = can_link(rowa_q, b_q) && can_link(slot_row, a_q);
			new_a  = add_link(rowa_q, b_q);
			new_b  = add_link(slot_row, a_q);
			lk_two = 1'b1;
		end else begin
			lk_ok  = has_link(rowa_q, b_q) && has_link(slot_row, a_q);
			new_a  = remove_link(rowa_q, b_q);
			new_b  = remove_link(slot_row, a_q);
			lk_two = a_q != b_q;
		end
	end

	// lane score of edge (i, cand) against the world position
	logic [7:0]         cx, cz, p, q, lo, hi, gg, base;
	logic [15:0]        w;
	logic               vert, horiz, neg, in_rng;
	logic signed [17:0] e, d, t;
	logic [17:0]        s_full;
	logic [16:0]        score;

	always_comb begin
		cx     = coord_rdata[15:8];
		cz     = coord_rdata[7:0];
		vert   = ix_q == cx;
		horiz  = iz_q == cz;
		p      = vert ? iz_q : ix_q;
		q      = vert ? cz : cx;
		gg     = vert ? wz_q[15:8] : wx_q[15:8];
		w      = vert ? wx_q : wz_q;
		base   = vert ? ix_q : iz_q;
		lo     = (p < q) ? p : q;
		hi     = (p < q) ? q : p;
		neg    = vert ? (p < q) : (p > q);
		in_rng = ({2'b00, gg} + bdgt_pkg::LANE_MARGIN >= {2'b00, lo})
			&& ({2'b00, gg} <= {2'b00, hi} + bdgt_pkg::LANE_MARGIN);
		e      = $signed({2'b00, w}) - $signed({2'b00, base, bdgt_pkg::LANE_HALF});
		if (!(vert || horiz) || !in_rng) begin
			d = $signed(bdgt_pkg::LANE_FAR);
		end else begin
			d = neg ? -e : e;
		end
		t      = $signed(bdgt_pkg::LANE_OFS) - d;
		s_full = (t < 0) ? 18'(-t) : 18'(t);
		score  = s_full[16:0];
	end

	always_comb begin
		coord_raddr = (state_q == S_NS_SLOT) ? cand : i_q;
		coord_we    = state_q == S_FA_NEW && cnt_q != CNT_MAX;
		coord_waddr = cnt_q[NW-1:0];
		coord_wdata = {x_q, z_q};
		if (state_q == S_LK_RDA) begin
			slot_raddr = a_q;
		end else if (state_q == S_LK_RDB) begin
			slot_raddr = b_q;
		end else begin
			slot_raddr = i_q;
		end
		slot_we    = coord_we || (state_q == S_LK_EVAL && lk_ok) || state_q == S_LK_WRB;
		slot_waddr = a_q;
		slot_wrow  = new_a;
		if (state_q == S_FA_NEW) begin
			slot_waddr = cnt_q[NW-1:0];
			slot_wrow  = '0;
		end else if (state_q == S_LK_WRB) begin
			slot_waddr = b_q;
			slot_wrow  = newb_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= CNT_ONE;
			done_q    <= 1'b0;
			best_v_q  <= 1'b0;
			op_q      <= '0;
			i_q       <= '0;
			a_q       <= '0;
			b_q       <= '0;
			cand_q    <= '0;
			x_q       <= '0;
			z_q       <= '0;
			ix_q      <= '0;
			iz_q      <= '0;
			wx_q      <= '0;
			wz_q      <= '0;
			rowa_q    <= '0;
			row_q     <= '0;
			newb_q    <= '0;
			j_q       <= '0;
			score_q   <= '0;
			best_q    <= '0;
			node_q    <= '0;
			other_q   <= '0;
			created_q <= 1'b0;
			degree_q  <= '0;
			status_q  <= bdgt_pkg::ST_OK;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q      <= op;
						node_q    <= '0;
						other_q   <= '0;
						created_q <= 1'b0;
						degree_q  <= '0;
						status_q  <= bdgt_pkg::ST_OK;
						x_q       <= grid_x;
						z_q       <= grid_z;
						wx_q      <= world_x;
						wz_q      <= world_z;
						a_q       <= na_ext[NW-1:0];
						b_q       <= nb_ext[NW-1:0];
						i_q       <= NW'(1);
						best_v_q  <= 1'b0;
						case (op)
							bdgt_pkg::OP_FIND: begin
								state_q <= (cnt_q == CNT_ONE) ? S_FA_NEW : S_FA_RD;
							end
							bdgt_pkg::OP_CONNECT, bdgt_pkg::OP_DISCONNECT: begin
								if (!a_ok || !b_ok) begin
									status_q <= bdgt_pkg::ST_BADIDX;
									done_q   <= 1'b1;
								end else begin
									state_q <= S_LK_RDA;
								end
							end
							bdgt_pkg::OP_DEGREE: begin
								if (!a_ok) begin
									status_q <= bdgt_pkg::ST_BADIDX;
									done_q   <= 1'b1;
								end else begin
									state_q <= S_LK_RDA;
								end
							end
							bdgt_pkg::OP_NEAREST: begin
								if (cnt_q == CNT_ONE) begin
									done_q <= 1'b1;
								end else begin
									state_q <= S_NS_ROW;
								end
							end
							bdgt_pkg::OP_CLEAR: begin
								cnt_q  <= CNT_ONE;
								done_q <= 1'b1;
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				S_FA_RD: begin
					state_q <= S_FA_CMP;
				end
				S_FA_CMP: begin
					if (coord_rdata == {x_q, z_q}) begin
						node_q  <= i_q;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else if (last_node) begin
						state_q <= S_FA_NEW;
					end else begin
						i_q     <= i_q + NW'(1);
						state_q <= S_FA_RD;
					end
				end
				S_FA_NEW: begin
					if (cnt_q == CNT_MAX) begin
						status_q <= bdgt_pkg::ST_FULL;
					end else begin
						node_q    <= cnt_q[NW-1:0];
						created_q <= 1'b1;
						cnt_q     <= cnt_q + CNT_ONE;
					end
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_LK_RDA: begin
					state_q <= S_LK_RDB;
				end
				S_LK_RDB: begin
					if (op_q == bdgt_pkg::OP_DEGREE) begin
						degree_q <= count_used(slot_row);
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						rowa_q  <= slot_row;
						state_q <= S_LK_EVAL;
					end
				end
				S_LK_EVAL: begin
					newb_q <= new_b;
					if (!lk_ok) begin
						status_q <= (op_q == bdgt_pkg::OP_CONNECT) ?
							bdgt_pkg::ST_NOSLOT : bdgt_pkg::ST_NOTCONN;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else if (lk_two) begin
						state_q <= S_LK_WRB;
					end else begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_LK_WRB: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_NS_ROW: begin
					state_q <= S_NS_ROWW;
				end
				S_NS_ROWW: begin
					row_q   <= slot_row;
					ix_q    <= coord_rdata[15:8];
					iz_q    <= coord_rdata[7:0];
					j_q     <= '0;
					state_q <= S_NS_SLOT;
				end
				S_NS_SLOT: begin
					if (j_q == J_END || cand == '0) begin
						if (last_node) begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							i_q     <= i_q + NW'(1);
							state_q <= S_NS_ROW;
						end
					end else if (cand < i_q) begin
						cand_q  <= cand;
						state_q <= S_NS_SCORE;
					end else begin
						j_q <= j_q + JW'(1);
					end
				end
				S_NS_SCORE: begin
					score_q <= score;
					state_q <= S_NS_CMP;
				end
				S_NS_CMP: begin
					if (!best_v_q || score_q < best_q) begin
						best_v_q <= 1'b1;
						best_q   <= score_q;
						node_q   <= i_q;
						other_q  <= cand_q;
					end
					j_q     <= j_q + JW'(1);
					state_q <= S_NS_SLOT;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy       = state_q != S_IDLE;
	assign done       = done_q;
	assign node_index = to_byte(node_q);
	assign other_node = to_byte(other_q);
	assign created    = created_q;
	assign degree     = degree_q;
	assign status     = status_q;

endmodule

[dv/bounded_degree_graph_table_top_tb.sv]
// Self-checking bench for bounded_degree_graph_table_top: directed, table-full and random
// command streams, each answer scored against an in-bench model of the node table.
// Depends on bdgt_pkg and the block's RTL.
module bounded_degree_graph_table_top_tb;
	import bdgt_pkg::*;

	localparam int NODES       = MAX_NODES_DEF;
	localparam int SLOTS       = SLOTS_DEF;
	localparam int STALL_LIMIT = 20000;
	localparam op_t OP_SPARE_6 = 3'd6;
	localparam op_t OP_SPARE_7 = 3'd7;

	typedef struct packed {
		op_t         op;
		logic [7:0]  gx;
		logic [7:0]  gz;
		logic [7:0]  na;
		logic [7:0]  nb;
		logic [15:0] wx;
		logic [15:0] wz;
	} beat_t;

	typedef struct packed {
		logic [7:0] node;
		logic [7:0] other;
		logic       made;
		logic [2:0] deg;
		status_t    st;
	} answer_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	op_t         op = OP_FIND;
	logic [7:0]  grid_x = '0;
	logic [7:0]  grid_z = '0;
	logic [7:0]  node_a = '0;
	logic [7:0]  node_b = '0;
	logic [15:0] world_x = '0;
	logic [15:0] world_z = '0;
	logic        busy;
	logic        done;
	logic [7:0]  node_index;
	logic [7:0]  other_node;
	logic        created;
	logic [2:0]  degree;
	status_t     status;

	logic [7:0]  grid_xs [NODES];
	logic [7:0]  grid_zs [NODES];
	logic [15:0] links [NODES][SLOTS];
	int          node_total;

	answer_t     pending_answers [$];
	int          mismatches = 0;
	int          answers_checked = 0;
	int          beats_sent = 0;
	int          op_seen [8];
	int          stall_cycles = 0;
	int          idle_pct = 0;
	int          burst_left = 0;
	int          win_x = 0;
	int          win_z = 0;

	bounded_degree_graph_table_top i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.op         (op),
		.grid_x     (grid_x),
		.grid_z     (grid_z),
		.node_a     (node_a),
		.node_b     (node_b),
		.world_x    (world_x),
		.world_z    (world_z),
		.busy       (busy),
		.done       (done),
		.node_index (node_index),
		.other_node (other_node),
		.created    (created),
		.degree     (degree),
		.status     (status)
	);

	always #5 clk = ~clk;

	function automatic void wipe_table();
		node_total = 1;
		for (int i = 0; i < NODES; i++) begin
			grid_xs[i] = '0;
			grid_zs[i] = '0;
			for (int j = 0; j < SLOTS; j++)
				links[i][j] = '0;
		end
	endfunction

	function automatic bit live_node(int n);
		return n >= 1 && n < node_total && n < NODES;
	endfunction

	function automatic bit link_room(int n, int other);
		for (int i = 0; i < SLOTS; i++)
			if (links[n][i] == other || links[n][i] == 0)
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic void link_add(int n, int other);
		for (int i = 0; i < SLOTS; i++) begin
			if (links[n][i] == other)
				return;
			if (links[n][i] == 0) begin
				links[n][i] = 16'(other);
				return;
			end
		end
	endfunction

	function automatic int link_pos(int n, int other);
		for (int i = 0; i < SLOTS; i++)
			if (links[n][i] == other)
				return i;
		return -1;
	endfunction

	function automatic void link_drop(int n, int pos);
		for (int j = pos; j < SLOTS - 1; j++)
			links[n][j] = links[n][j + 1];
		links[n][SLOTS - 1] = '0;
	endfunction

	function automatic answer_t graph_answer(beat_t b);
		answer_t r;
		int a, c, n2, pa, pb, best, s, d, lo, hi, g, wx, wz, ax, az, bx, bz;
		int far_d, margin, half, ofs;
		bit hit;
		r = '0;
		r.st = ST_OK;
		a = b.na;
		c = b.nb;
		wx = b.wx;
		wz = b.wz;
		far_d = int'(LANE_FAR);
		margin = int'(LANE_MARGIN);
		half = int'(LANE_HALF);
		ofs = int'(LANE_OFS);
		case (b.op)
			OP_FIND: begin
				hit = 1'b0;
				for (int i = 1; i < node_total && i < NODES && !hit; i++)
					if (grid_xs[i] == b.gx && grid_zs[i] == b.gz) begin
						r.node = 8'(i);
						hit = 1'b1;
					end
				if (!hit) begin
					if (node_total >= NODES) begin
						r.st = ST_FULL;
					end else begin
						grid_xs[node_total] = b.gx;
						grid_zs[node_total] = b.gz;
						for (int j = 0; j < SLOTS; j++)
							links[node_total][j] = '0;
						r.node = 8'(node_total);
						r.made = 1'b1;
						node_total++;
					end
				end
			end
			OP_CONNECT: begin
				if (!live_node(a) || !live_node(c)) begin
					r.st = ST_BADIDX;
				end else if (!link_room(a, c) || !link_room(c, a)) begin
					r.st = ST_NOSLOT;
				end else begin
					link_add(a, c);
					link_add(c, a);
				end
			end
			OP_DISCONNECT: begin
				if (!live_node(a) || !live_node(c)) begin
					r.st = ST_BADIDX;
				end else begin
					pa = link_pos(a, c);
					pb = link_pos(c, a);
					if (pa < 0 || pb < 0) begin
						r.st = ST_NOTCONN;
					end else begin
						link_drop(a, pa);
						if (a != c) begin
							pb = link_pos(c, a);
							if (pb >= 0)
								link_drop(c, pb);
						end
					end
				end
			end
			OP_DEGREE: begin
				if (!live_node(a)) begin
					r.st = ST_BADIDX;
				end else begin
					for (int j = 0; j < SLOTS; j++)
						if (links[a][j] != 0)
							r.deg++;
				end
			end
			OP_NEAREST: begin
				best = 32'h7fff_ffff;
				for (int i = 1; i < node_total && i < NODES; i++)
					for (int j = 0; j < SLOTS && links[i][j] != 0; j++) begin
						n2 = links[i][j];
						if (n2 < i) begin
							ax = grid_xs[i];
							az = grid_zs[i];
							bx = grid_xs[n2];
							bz = grid_zs[n2];
							d = far_d;
							if (ax == bx) begin
								lo = az < bz ? az : bz;
								hi = az < bz ? bz : az;
								g = wz / 256;
								if (g >= lo - margin && g <= hi + margin) begin
									d = wx - (ax * 256 + half);
									if (az < bz)
										d = -d;
								end
							end else if (az == bz) begin
								lo = ax < bx ? ax : bx;
								hi = ax < bx ? bx : ax;
								g = wx / 256;
								if (g >= lo - margin && g <= hi + margin) begin
									d = wz - (az * 256 + half);
									if (ax > bx)
										d = -d;
								end
							end
							s = ofs - d;
							if (s < 0)
								s = -s;
							if (s < best) begin
								best = s;
								r.node = 8'(i);
								r.other = 8'(n2);
							end
						end
					end
			end
			OP_CLEAR: wipe_table();
			default: ;
		endcase
		return r;
	endfunction

	function automatic beat_t noise_beat();
		beat_t b;
		b = beat_t'({$urandom, $urandom, $urandom});
		b.op = op_t'($urandom_range(0, 7));
		return b;
	endfunction

	function automatic beat_t find_beat(logic [7:0] x, logic [7:0] z);
		beat_t b;
		b = noise_beat();
		b.op = OP_FIND;
		b.gx = x;
		b.gz = z;
		return b;
	endfunction

	function automatic beat_t link_beat(op_t code, logic [7:0] a, logic [7:0] c);
		beat_t b;
		b = noise_beat();
		b.op = code;
		b.na = a;
		b.nb = c;
		return b;
	endfunction

	function automatic beat_t probe_beat(logic [15:0] x, logic [15:0] z);
		beat_t b;
		b = noise_beat();
		b.op = OP_NEAREST;
		b.wx = x;
		b.wz = z;
		return b;
	endfunction

	function automatic logic [7:0] some_node();
		if (node_total > 1)
			return 8'($urandom_range(1, node_total - 1));
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic flag_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		mismatches++;
	endtask

	task automatic pause_sender(input int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic idle_gap();
		if (burst_left > 0) begin
			burst_left--;
		end else if ($urandom_range(0, 99) < idle_pct) begin
			pause_sender($urandom_range(1, 12));
		end else if ($urandom_range(0, 19) == 0) begin
			burst_left = $urandom_range(5, 15);
		end
	endtask

	task automatic wait_drained();
		if (pending_answers.size() != 0) begin
			start <= 1'b0;
			while (pending_answers.size() != 0)
				@(posedge clk);
		end
	endtask

	// Call at a rising edge; returns at an edge where busy is low, after the beat is taken.
	task automatic send_beat(input beat_t b);
		start <= 1'b1;
		op <= b.op;
		grid_x <= b.gx;
		grid_z <= b.gz;
		node_a <= b.na;
		node_b <= b.nb;
		world_x <= b.wx;
		world_z <= b.wz;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		pending_answers.push_back(graph_answer(b));
		op_seen[b.op]++;
		beats_sent++;
		idle_gap();
	endtask

	task automatic test_directed();
		beat_t b;
		idle_pct = 0;
		send_beat(probe_beat(16'h0000, 16'h0000));
		send_beat(link_beat(OP_DEGREE, 8'd1, 8'd0));
		send_beat(find_beat(8'd10, 8'd10));
		send_beat(find_beat(8'd10, 8'd12));
		send_beat(find_beat(8'd13, 8'd10));
		send_beat(find_beat(8'd11, 8'd11));
		send_beat(find_beat(8'd255, 8'd255));
		send_beat(find_beat(8'd0, 8'd0));
		send_beat(find_beat(8'd10, 8'd10));
		send_beat(link_beat(OP_CONNECT, 8'd1, 8'd2));
		send_beat(link_beat(OP_CONNECT, 8'd1, 8'd3));
		send_beat(link_beat(OP_CONNECT, 8'd1, 8'd4));
		send_beat(link_beat(OP_CONNECT, 8'd1, 8'd1));
		send_beat(link_beat(OP_CONNECT, 8'd1, 8'd5));
		send_beat(link_beat(OP_CONNECT, 8'd1, 8'd2));
		send_beat(link_beat(OP_CONNECT, 8'd0, 8'd2));
		send_beat(link_beat(OP_CONNECT, 8'd2, 8'd7));
		send_beat(link_beat(OP_CONNECT, 8'd6, 8'd5));
		send_beat(link_beat(OP_DEGREE, 8'd1, 8'd0));
		send_beat(link_beat(OP_DEGREE, 8'd255, 8'd0));
		send_beat(probe_beat(16'd2944, 16'd2816));
		send_beat(probe_beat(16'd2816, 16'd2432));
		send_beat(probe_beat(16'hffff, 16'hffff));
		send_beat(link_beat(OP_DISCONNECT, 8'd2, 8'd3));
		send_beat(link_beat(OP_DISCONNECT, 8'd1, 8'd3));
		send_beat(link_beat(OP_DISCONNECT, 8'd1, 8'd1));
		send_beat(link_beat(OP_DEGREE, 8'd1, 8'd0));
		b = noise_beat();
		b.op = OP_SPARE_6;
		send_beat(b);
		b = noise_beat();
		b.op = OP_SPARE_7;
		send_beat(b);
		send_beat(link_beat(OP_CLEAR, 8'd0, 8'd0));
		send_beat(link_beat(OP_DEGREE, 8'd1, 8'd0));
		wait_drained();
	endtask

	task automatic test_table_full();
		idle_pct = 65;
		send_beat(link_beat(OP_CLEAR, 8'd0, 8'd0));
		for (int k = 1; k < NODES; k++)
			send_beat(find_beat(8'(8 + k % 16), 8'(8 + k / 16)));
		send_beat(find_beat(8'd8, 8'd8));
		send_beat(find_beat(8'd23, 8'd23));
		for (int k = 240; k < 255; k++)
			send_beat(link_beat(OP_CONNECT, 8'(k), 8'(k + 1)));
		for (int k = 250; k < 256; k++)
			send_beat(link_beat(OP_CONNECT, 8'(k), 8'(k - 16)));
		send_beat(link_beat(OP_CONNECT, 8'd255, 8'd255));
		send_beat(link_beat(OP_DEGREE, 8'd255, 8'd0));
		send_beat(probe_beat(16'd5220, 16'd6016));
		send_beat(probe_beat(16'd0, 16'd0));
		send_beat(probe_beat(16'hffff, 16'd6088));
		send_beat(link_beat(OP_DISCONNECT, 8'd255, 8'd254));
		send_beat(link_beat(OP_DISCONNECT, 8'd255, 8'd1));
		send_beat(link_beat(OP_CONNECT, 8'd255, 8'd0));
		send_beat(find_beat(8'd0, 8'd0));
		wait_drained();
		send_beat(link_beat(OP_CLEAR, 8'd0, 8'd0));
	endtask

	task automatic test_random(input int pct, input int count);
		beat_t b;
		int pick, used;
		logic [7:0] a, partner;
		idle_pct = pct;
		win_x = $urandom_range(0, 252);
		win_z = $urandom_range(0, 252);
		repeat (count) begin
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				b = find_beat(8'(win_x + int'($urandom_range(0, 3))),
					8'(win_z + int'($urandom_range(0, 3))));
			end else if (pick < 52) begin
				b = link_beat(OP_CONNECT, some_node(), some_node());
			end else if (pick < 64) begin
				a = some_node();
				used = 0;
				for (int j = 0; j < SLOTS; j++)
					if (links[a][j] != 0)
						used++;
				partner = used > 0 ? 8'(links[a][$urandom_range(0, used - 1)]) : some_node();
				b = link_beat(OP_DISCONNECT, a, partner);
			end else if (pick < 72) begin
				b = link_beat(OP_DEGREE, some_node(), 8'($urandom));
			end else if (pick < 84) begin
				b = probe_beat(
					16'((win_x + int'($urandom_range(0, 5)) - 1) * 256
						+ int'($urandom_range(0, 255))),
					16'((win_z + int'($urandom_range(0, 5)) - 1) * 256
						+ int'($urandom_range(0, 255))));
			end else if (pick < 87) begin
				b = link_beat(OP_CLEAR, 8'($urandom), 8'($urandom));
				win_x = $urandom_range(0, 252);
				win_z = $urandom_range(0, 252);
			end else begin
				b = noise_beat();
			end
			send_beat(b);
			if ($urandom_range(0, 49) == 0)
				wait_drained();
		end
	endtask

	always @(posedge clk) begin : check_answers
		answer_t want;
		if (arst_n && done === 1'b1) begin
			if (pending_answers.size() == 0) begin
				flag_mismatch($sformatf("answer with none pending: node %0d status %0d",
					node_index, status));
			end else begin
				want = pending_answers.pop_front();
				answers_checked++;
				if (node_index !== want.node)
					flag_mismatch($sformatf("answer %0d node_index %0d, want %0d",
						answers_checked, node_index, want.node));
				if (other_node !== want.other)
					flag_mismatch($sformatf("answer %0d other_node %0d, want %0d",
						answers_checked, other_node, want.other));
				if (created !== want.made)
					flag_mismatch($sformatf("answer %0d created %0d, want %0d",
						answers_checked, created, want.made));
				if (degree !== want.deg)
					flag_mismatch($sformatf("answer %0d degree %0d, want %0d",
						answers_checked, degree, want.deg));
				if (status !== want.st)
					flag_mismatch($sformatf("answer %0d status %0d, want %0d",
						answers_checked, status, want.st));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("Watchdog: no beat for %0d cycles", STALL_LIMIT);
			$display("Regression FAIL");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		wipe_table();
		for (int i = 0; i < 8; i++)
			op_seen[i] = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_table_full();
		test_random(0, 150);
		test_random(65, 150);
		test_random(27, 150);
		start <= 1'b0;
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		$display("Covered %0d beats, %0d answers checked, including a full table",
			beats_sent, answers_checked);
		$display("Ops: find %0d connect %0d disconnect %0d degree %0d nearest %0d clear %0d other %0d",
			op_seen[OP_FIND], op_seen[OP_CONNECT], op_seen[OP_DISCONNECT], op_seen[OP_DEGREE],
			op_seen[OP_NEAREST], op_seen[OP_CLEAR], op_seen[OP_SPARE_6] + op_seen[OP_SPARE_7]);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

[filelist.f]
rtl/bdgt_pkg.sv
rtl/bdgt_ram.sv
rtl/bounded_degree_graph_table_top.sv
dv/bounded_degree_graph_table_top_tb.sv
